// File: design/circular_deque_unit_defines.svh
// Assertion macros shared by the circular deque RTL.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/cdq_pkg.sv
// Shared types and constants for the circular deque.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    // Field widths
    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Stream payload widths, padded to whole bytes
    localparam int IN_W  = 40;   // op(3) + value(32) = 35
    localparam int OUT_W = 72;   // ok(1) + front(32) + rear(32) + empty(1) + full(1) = 67

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_NOP        = 3'd4;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Value reported for front and rear of an empty deque
    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    // What a cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_LOAD
    } cell_mode_t;

endpackage

`default_nettype wire

// File: design/cdq_cell.sv
// One storage cell of the deque chain: holds one entry, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell
    import cdq_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_mode_t        mode,
    input  wire logic [DATA_W-1:0] push_value,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] data_q,
    output logic      [DATA_W-1:0] data_next
);

    logic [DATA_W-1:0] data_reg;

    // Pick the entry this cell holds after the current cycle
    always_comb
    begin
        case (mode)
            CELL_FROM_LEFT:  data_next = left_data;
            CELL_FROM_RIGHT: data_next = right_data;
            CELL_LOAD:       data_next = push_value;
            default:         data_next = data_reg;
        endcase
    end

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

`default_nettype wire

// File: design/circular_deque_unit.sv
// Top level of the circular deque: cell chain, occupancy count and stream ports.
// The deque keeps its entries in order in a chain of cells, front in cell 0 and rear in
// cell count-1; a push at the front or a pop from the front shifts the whole chain by one
// place, a push at the back loads the cell just past the rear. Every accepted item gives
// exactly one result item, registered and valid in the cycle after it is accepted, and a
// new item is taken in every cycle as long as the result register is empty or being
// drained, so the block sustains one item per clock in that case. Writing the
// capacity register (1..31, 0 acts as 1, values above MAX_DEPTH act as MAX_DEPTH) empties
// the deque at once; the configuration port is always ready and there is no clearing pass
// after reset. Entries beyond the live count are never reported.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_unit_defines.svh"

module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int MAX_DEPTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input item stream
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // op[2:0], value[34:3], zeros above
    // result item stream
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [OUT_W-1:0] m_axis_tdata,   // ok[0], front_value[32:1],
                                                  // rear_value[64:33], is_empty[65],
                                                  // is_full[66], zeros above
    // capacity register write
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    // Registers
    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    // Item decode
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic              in_accept, cfg_accept;
    logic [CNT_W-1:0]  eff_cap;
    logic              is_full_now;
    logic              do_push_front, do_push_back, do_pop_front, do_pop_back;
    logic              item_ok;

    // Cell chain
    cell_mode_t        cell_mode [MAX_DEPTH];
    logic [DATA_W-1:0] cell_q    [MAX_DEPTH];
    logic [DATA_W-1:0] cell_nx   [MAX_DEPTH];
    logic [IDX_W-1:0]  rear_idx;
    logic              empty_next, full_next;
    logic [DATA_W-1:0] front_word, rear_word;

    // Check helpers
    logic              fail_item;
    logic              empty_words_ok;

    assign op    = s_axis_tdata[OP_W-1:0];
    assign value = s_axis_tdata[OP_W +: DATA_W];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_accept    = cfg_valid && cfg_ready;

    // Capacity in use: zero acts as one, large values clamp to the chain length
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CNT_W'(1);
        else if (32'(cap_reg) > 32'(MAX_DEPTH))
            eff_cap = CNT_W'(MAX_DEPTH);
        else
            eff_cap = CNT_W'(cap_reg);
    end

    assign is_full_now = (cnt_reg == eff_cap);

    // Operation decode with full/empty checks
    always_comb
    begin
        do_push_front = 1'b0;
        do_push_back  = 1'b0;
        do_pop_front  = 1'b0;
        do_pop_back   = 1'b0;
        item_ok       = 1'b1;
        case (op)
            OP_PUSH_FRONT:
            begin
                item_ok       = !is_full_now;
                do_push_front = in_accept && !is_full_now;
            end
            OP_PUSH_BACK:
            begin
                item_ok      = !is_full_now;
                do_push_back = in_accept && !is_full_now;
            end
            OP_POP_FRONT:
            begin
                item_ok      = (cnt_reg != '0);
                do_pop_front = in_accept && (cnt_reg != '0);
            end
            OP_POP_BACK:
            begin
                item_ok     = (cnt_reg != '0);
                do_pop_back = in_accept && (cnt_reg != '0);
            end
            OP_NOP:  item_ok = 1'b1;
            default: item_ok = 1'b1;
        endcase
    end

    // Count after the item
    always_comb
    begin
        if (do_push_front || do_push_back)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop_front || do_pop_back)
            cnt_next = cnt_reg - CNT_W'(1);
        else
            cnt_next = cnt_reg;
    end

    // Per-cell mode and the cells themselves
    for (genvar i = 0; i < MAX_DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_in, right_in;

        always_comb
        begin
            if (do_push_front)
                cell_mode[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
            else if (do_push_back && (cnt_reg == CNT_W'(i)))
                cell_mode[i] = CELL_LOAD;
            else if (do_pop_front)
                cell_mode[i] = CELL_FROM_RIGHT;
            else
                cell_mode[i] = CELL_HOLD;
        end

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_l
            assign left_in = cell_q[i-1];
        end

        if (i == MAX_DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = cell_q[i+1];
        end

        cdq_cell u_cell (
            .clk        (clk),
            .mode       (cell_mode[i]),
            .push_value (value),
            .left_data  (left_in),
            .right_data (right_in),
            .data_q     (cell_q[i]),
            .data_next  (cell_nx[i])
        );
    end

    // Result fields seen after the item
    assign empty_next = (cnt_next == '0);
    assign full_next  = (cnt_next == eff_cap);
    assign rear_idx   = IDX_W'(cnt_next - CNT_W'(1));
    assign front_word = empty_next ? EMPTY_WORD : cell_nx[0];
    assign rear_word  = empty_next ? EMPTY_WORD : cell_nx[rear_idx];

    always_comb
    begin
        out_data_next = '0;
        out_data_next[0]            = item_ok;
        out_data_next[1 +: DATA_W]  = front_word;
        out_data_next[33 +: DATA_W] = rear_word;
        out_data_next[65]           = empty_next;
        out_data_next[66]           = full_next;
    end

    // Control state: capacity, count, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_accept)
            begin
                cap_reg <= cfg_data;
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
            end
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks
    assign fail_item      = in_accept && !item_ok && !cfg_accept;
    assign empty_words_ok = (m_axis_tdata[32:1] == EMPTY_WORD)
                         && (m_axis_tdata[64:33] == EMPTY_WORD);

    `CDQ_ASSERT_NOW(a_cnt_bound, 1'b1, 32'(cnt_reg) <= 32'(MAX_DEPTH), "count beyond chain")
    `CDQ_ASSERT_NEXT(a_fail_keeps_cnt, fail_item, $stable(cnt_reg), "failed item changed count")
    `CDQ_ASSERT_NEXT(a_result_follows, in_accept, m_axis_tvalid, "accepted item gave no result")
    `CDQ_ASSERT_NOW(a_empty_words, m_axis_tvalid && m_axis_tdata[65], empty_words_ok, "live words")

endmodule

`default_nettype wire

// File: verif/circular_deque_checker.sv
// Checker for the circular deque: mirrors the deque from the stream traffic and compares every result.
`timescale 1ns / 1ps

module circular_deque_checker
    import cdq_pkg::*;
#(
    parameter int MAX_DEPTH = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // op[2:0], value[34:3], zeros above
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [OUT_W-1:0] m_axis_tdata,   // ok[0], front_value[32:1],
                                                  // rear_value[64:33], is_empty[65],
                                                  // is_full[66], zeros above
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data,
    output int                    mismatch_cnt,
    output int                    results_pending
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] rear_value;
        logic              is_empty;
        logic              is_full;
    } deque_result_t;

    // Mirror of the deque
    logic [DATA_W-1:0] ring_copy [MAX_DEPTH];
    int unsigned       front_ptr;
    int unsigned       rear_ptr;
    logic              deque_empty;
    logic [CAP_W-1:0]  capacity_reg;

    deque_result_t     predicted_results [$];
    int                error_total;

    // Ring size in use: 0 acts as 1, anything above the store acts as the store
    function automatic int unsigned ring_limit();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > MAX_DEPTH)
            return MAX_DEPTH;
        return capacity_reg;
    endfunction

    function automatic int unsigned step_up(input int unsigned i);
        return (i + 1 >= ring_limit()) ? 0 : i + 1;
    endfunction

    function automatic int unsigned step_down(input int unsigned i);
        return (i == 0) ? ring_limit() - 1 : i - 1;
    endfunction

    function automatic logic ring_full();
        return !deque_empty && step_up(rear_ptr) == front_ptr;
    endfunction

    task automatic clear_deque();
        front_ptr   = 0;
        rear_ptr    = 0;
        deque_empty = 1'b1;
    endtask

    // Apply one operation to the mirror and work out the result item
    task automatic run_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word,
                          output deque_result_t res);
        logic done;
        done = 1'b1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (ring_full())
                    done = 1'b0;
                else if (deque_empty)
                begin
                    // first entry always lands in slot 0
                    front_ptr    = 0;
                    rear_ptr     = 0;
                    deque_empty  = 1'b0;
                    ring_copy[0] = word;
                end
                else if (op == OP_PUSH_FRONT)
                begin
                    front_ptr            = step_down(front_ptr);
                    ring_copy[front_ptr] = word;
                end
                else
                begin
                    rear_ptr            = step_up(rear_ptr);
                    ring_copy[rear_ptr] = word;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (deque_empty)
                    done = 1'b0;
                else if (front_ptr == rear_ptr)
                    clear_deque();
                else if (op == OP_POP_FRONT)
                    front_ptr = step_up(front_ptr);
                else
                    rear_ptr = step_down(rear_ptr);
            end
            default:
            begin
                // no change, unused codes included
            end
        endcase
        res.ok          = done;
        res.front_value = deque_empty ? EMPTY_WORD : ring_copy[front_ptr];
        res.rear_value  = deque_empty ? EMPTY_WORD : ring_copy[rear_ptr];
        res.is_empty    = deque_empty;
        res.is_full     = ring_full();
    endtask

    // Track config writes and input items, check result items in order
    always @(posedge clk or negedge rst_n)
    begin : watch
        deque_result_t expected_r;
        deque_result_t seen_r;
        logic          bad;
        if (!rst_n)
        begin
            capacity_reg = CAP_RESET;
            clear_deque();
            predicted_results.delete();
            error_total = 0;
            mismatch_cnt    <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg = cfg_data;
                clear_deque();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                run_op(s_axis_tdata[OP_W-1:0], s_axis_tdata[OP_W +: DATA_W], expected_r);
                predicted_results.push_back(expected_r);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_r.ok          = m_axis_tdata[0];
                seen_r.front_value = m_axis_tdata[32:1];
                seen_r.rear_value  = m_axis_tdata[64:33];
                seen_r.is_empty    = m_axis_tdata[65];
                seen_r.is_full     = m_axis_tdata[66];
                if (predicted_results.size() == 0)
                begin
                    error_total++;
                    if (error_total <= REPORT_MAX)
                        $display("%0t: result item with nothing expected: ok=%0d front=%h rear=%h empty=%0d full=%0d",
                                 $time, seen_r.ok, seen_r.front_value, seen_r.rear_value,
                                 seen_r.is_empty, seen_r.is_full);
                end
                else
                begin
                    expected_r = predicted_results.pop_front();
                    bad = (seen_r.ok !== expected_r.ok)
                       || (seen_r.front_value !== expected_r.front_value)
                       || (seen_r.rear_value !== expected_r.rear_value)
                       || (seen_r.is_empty !== expected_r.is_empty)
                       || (seen_r.is_full !== expected_r.is_full);
                    if (bad)
                    begin
                        error_total++;
                        if (error_total <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch, expected ok=%0d front=%h rear=%h empty=%0d full=%0d",
                                     $time, expected_r.ok, expected_r.front_value,
                                     expected_r.rear_value, expected_r.is_empty,
                                     expected_r.is_full);
                            $display("%0t:           got      ok=%0d front=%h rear=%h empty=%0d full=%0d",
                                     $time, seen_r.ok, seen_r.front_value, seen_r.rear_value,
                                     seen_r.is_empty, seen_r.is_full);
                        end
                    end
                end
            end
            results_pending <= predicted_results.size();
            mismatch_cnt    <= error_total;
        end
    end

endmodule

// File: verif/tb_circular_deque_unit.sv
// Testbench top for the circular deque: clock, reset, item stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_circular_deque_unit;
    import cdq_pkg::*;

    localparam int DEPTH           = 16;
    localparam int N_PHASES        = 11;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int LONG_HOLD       = 80;
    localparam int HOLD_PHASE_A    = 3;
    localparam int HOLD_PHASE_B    = 7;
    localparam int PAUSE_PHASE     = 5;
    localparam int STALL_LIMIT     = 2000;

    // Op codes the block treats as no change
    localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_C = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;   // op[2:0], value[34:3], zeros above
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // ok[0], front_value[32:1], rear_value[64:33],
                                      // is_empty[65], is_full[66], zeros above
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int items_sent;
    int cap_writes;
    int holds_asked;
    bit quiet_tail;

    circular_deque_unit #(.MAX_DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    circular_deque_checker #(.MAX_DEPTH(DEPTH)) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .mismatch_cnt    (mismatches),
        .results_pending (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: too many cycles with no item moving on any port ends the run
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: %0d cycles with no item moving", idle_cycles);
                $display("tb_circular_deque_unit: done, errors");
                $finish;
            end
        end
    end

    // Result sink: random stall bursts, long holds on request, none in the tail
    initial
    begin : result_sink
        int unsigned stall_pct;
        int unsigned regime_left;
        int          holds_done;
        stall_pct   = 0;
        regime_left = 0;
        holds_done  = 0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_asked > holds_done)
            begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!quiet_tail && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            // switch stall rate now and then, zero included
            if (regime_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
                regime_left = $urandom_range(40, 200);
            end
            else
                regime_left--;
        end
    end

    // Offer one item and hold it until taken; valid stays high afterwards
    task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] word);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - OP_W - DATA_W){1'b0}}, word, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every result item has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    function automatic logic [CAP_W-1:0] cap_for_phase(input int p);
        case (p)
            0: return 5'd16;
            1: return 5'd0;
            2: return 5'd31;
            3: return 5'd2;
            4: return 5'd1;
            5: return 5'd5;
            6: return 5'd17;
            7: return 5'd16;
            8: return 5'd3;
            9: return 5'd9;
            default: return 5'd16;
        endcase
    endfunction

    // Data word: mostly random, sometimes an extreme
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // Op: push-heavy while filling, pop-heavy while draining, a few no-change codes
    function automatic logic [OP_W-1:0] pick_op(input bit filling);
        int unsigned      r;
        logic [OP_W-1:0]  op;
        r = $urandom_range(0, 99);
        if (r < 6)
            op = OP_W'($urandom_range(OP_NOP, OP_RESERVED_C));
        else if (r < (filling ? 80 : 36))
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        return op;
    endfunction

    // Main stimulus
    initial
    begin : stimulus
        int          phase;
        int          k;
        int unsigned gap_pct;
        int unsigned trend_left;
        bit          filling;
        bit          hold_phase;
        items_sent  = 0;
        cap_writes  = 0;
        holds_asked = 0;
        quiet_tail  = 1'b0;
        filling     = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, no-change codes, pushes of extreme words, pop to empty
        send_item(OP_POP_FRONT, 32'h1234_5678);
        send_item(OP_POP_BACK, 32'h8765_4321);
        send_item(OP_NOP, 32'hdead_beef);
        send_item(OP_RESERVED_A, '1);
        send_item(OP_RESERVED_B, 32'h0000_0001);
        send_item(OP_RESERVED_C, '0);
        send_item(OP_PUSH_FRONT, 32'h8000_0000);
        send_item(OP_PUSH_BACK, 32'h7fff_ffff);
        send_item(OP_PUSH_FRONT, '0);
        send_item(OP_PUSH_BACK, '1);
        send_item(OP_POP_FRONT, 32'h5555_5555);
        send_item(OP_POP_BACK, 32'haaaa_aaaa);
        send_item(OP_POP_BACK, '0);
        send_item(OP_POP_FRONT, '1);

        // directed: single-entry ring, push on full, pop of the last entry
        write_capacity(5'd1);
        send_item(OP_PUSH_BACK, 32'ha5a5_a5a5);
        send_item(OP_PUSH_FRONT, 32'h5a5a_5a5a);
        send_item(OP_PUSH_BACK, 32'h0f0f_0f0f);
        send_item(OP_POP_BACK, '0);
        send_item(OP_PUSH_FRONT, 32'hf0f0_f0f0);
        send_item(OP_POP_FRONT, '1);

        // random phases, one capacity each; the last one runs without idling
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            write_capacity(cap_for_phase(phase));
            hold_phase = (phase == HOLD_PHASE_A) || (phase == HOLD_PHASE_B);
            if (phase == N_PHASES - 1)
                quiet_tail <= 1'b1;
            gap_pct    = 0;
            trend_left = 0;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (trend_left == 0)
                begin
                    filling    = ~filling;
                    trend_left = $urandom_range(4, 40);
                    if (!hold_phase && phase != N_PHASES - 1)
                        gap_pct = $urandom_range(0, 3) * 8;
                end
                trend_left--;
                // long output hold while the input keeps offering
                if (hold_phase && k == 10)
                    holds_asked <= holds_asked + 1;
                if (phase == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2)
                    wait_drained();
                if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
                send_item(pick_op(filling), pick_word());
            end
        end

        wait_drained();
        repeat (5) @(posedge clk);

        $display("covered: %0d items over %0d capacity writes (0, 1, 2, 16, 17, 31 among them)",
                 items_sent, cap_writes);
        $display("covered: full and empty rejects, wrap both ways, long output holds, drain pauses");
        if (pending != 0)
            $display("%0d result items never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("tb_circular_deque_unit: done, clean");
        else
            $display("tb_circular_deque_unit: done, errors");
        $finish;
    end

endmodule
